FILE: hw/rtl/plto_pkg.sv
// Shared constants, types and helper functions for the trajectory offset block.
package plto_pkg;

	localparam int MAX_POINTS = 16;
	localparam int NUM_JOINTS = 32;

	localparam int DATA_W    = 32;
	localparam int PT_W      = 4;
	localparam int JNT_W     = 5;
	localparam int CFG_W     = 5;
	localparam int OP_W      = 2;
	localparam int STAT_W    = 2;
	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 32;

	localparam int TIME_AW   = $clog2(MAX_POINTS);
	localparam int VAL_DEPTH = MAX_POINTS * NUM_JOINTS;
	localparam int VAL_AW    = $clog2(VAL_DEPTH);
	localparam int DIV_STEPS = 32;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [CFG_W-1:0] POINTS_RST = CFG_W'(2);

	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

	typedef enum logic [OP_W-1:0] {
		OP_WR_TIME = 2'd0,
		OP_WR_VAL  = 2'd1,
		OP_EVAL    = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_CLAMP = 2'd1,
		ST_ZERO  = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_V0,
		S_V1,
		S_V2,
		S_DIV,
		S_RAT,
		S_MUL,
		S_TERM,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic wr_time;
		logic wr_val;
		logic srch_ahead;
		logic cmp;
		logic rd_y1;
		logic diff;
		logic lat_y0;
		logic div_prep;
		logic lat_y1;
		logic div_step;
		logic ratio;
		logic mul;
		logic term;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic stop;
		logic div_skip;
		logic div_last;
		logic out_free;
	} stat_t;

	function automatic logic [VAL_AW-1:0] val_addr(input logic [TIME_AW-1:0] pt,
		input logic [JNT_W-1:0] jnt);
		return VAL_AW'(pt) * VAL_AW'(NUM_JOINTS) + VAL_AW'(jnt);
	endfunction

	function automatic logic pt_ok(input logic [PT_W-1:0] pt);
		return int'(pt) < MAX_POINTS;
	endfunction

	function automatic logic jnt_ok(input logic [JNT_W-1:0] jnt);
		return int'(jnt) < NUM_JOINTS;
	endfunction

endpackage

FILE: hw/rtl/piecewise_linear_trajectory_offset_top.sv
// Top level of the piecewise-linear trajectory offset block.
//
// Input stream (s_t*): one beat is a table write or an evaluation, selected by
// s_tuser. Time writes and value writes are taken while idle and give
// no output beat. An evaluation searches the pass times one per cycle, reads
// the two bracketing joint values, runs a 32-step radix-2 divider for the
// ratio, then a multiply, a scale and a saturating add.
// The search visits 2 to 16 pass times; the divider is skipped on a zero
// interval or when the ratio overflows. One evaluation is in flight at a time.
// Output stream (m_t*): one beat per evaluation from a registered output
// stage. If the receiver stalls, the result holds and a new beat is still
// accepted; the next evaluation waits at its final step until the stage frees.
// Reset clears the sequencer, the output stage and sets points_in_use to two;
// the tables keep no reset value and must be written before use.
// cfg_we/cfg_wdata write points_in_use; write it only while the block is idle.
module piecewise_linear_trajectory_offset_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// point_index[3:0], joint_index[8:4], time_value[40:9], data_value[72:41]
	input  logic [plto_pkg::S_TDATA_W-1:0]  s_tdata,
	// opcode[1:0]
	input  logic [plto_pkg::OP_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// joint_result[31:0]
	output logic [plto_pkg::M_TDATA_W-1:0]  m_tdata,
	// status[1:0]
	output logic [plto_pkg::STAT_W-1:0]     m_tuser,
	input  logic                            cfg_we,
	input  logic [plto_pkg::CFG_W-1:0]      cfg_wdata
);
	import plto_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	op_t   opcode;

	assign opcode = op_t'(s_tuser);

	plto_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.opcode  (opcode),
		.stat    (stat),
		.cmd     (cmd)
	);

	plto_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.point_index (s_tdata[3:0]),
		.joint_index (s_tdata[8:4]),
		.time_value  (s_tdata[40:9]),
		.data_value  (s_tdata[72:41]),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.joint_result(m_tdata),
		.status      (m_tuser)
	);

endmodule

FILE: hw/rtl/plto_ram.sv
// Generic single-write, single-read RAM with registered read data.
module plto_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/plto_ctrl.sv
// Sequencing state machine for table writes and evaluations.
module plto_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  plto_pkg::op_t          opcode,
	input  plto_pkg::stat_t        stat,
	output plto_pkg::cmd_t         cmd
);
	import plto_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && opcode == OP_EVAL) begin
					state_nxt = S_RD;
				end
			end
			S_RD: state_nxt = S_CMP;
			S_CMP: begin
				if (stat.stop) begin
					state_nxt = S_V0;
				end
			end
			S_V0: state_nxt = S_V1;
			S_V1: state_nxt = S_V2;
			S_V2: state_nxt = stat.div_skip ? S_RAT : S_DIV;
			S_DIV: begin
				if (stat.div_last) begin
					state_nxt = S_RAT;
				end
			end
			S_RAT:  state_nxt = S_MUL;
			S_MUL:  state_nxt = S_TERM;
			S_TERM: state_nxt = S_OUT;
			S_OUT: begin
				if (stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load    = accept && opcode == OP_EVAL;
				cmd.wr_time = accept && opcode == OP_WR_TIME;
				cmd.wr_val  = accept && opcode == OP_WR_VAL;
			end
			S_RD: cmd.srch_ahead = 1'b0;
			S_CMP: begin
				cmd.cmp        = 1'b1;
				cmd.srch_ahead = 1'b1;
			end
			S_V0: cmd.diff = 1'b1;
			S_V1: begin
				cmd.rd_y1    = 1'b1;
				cmd.lat_y0   = 1'b1;
				cmd.div_prep = 1'b1;
			end
			S_V2:   cmd.lat_y1   = 1'b1;
			S_DIV:  cmd.div_step = 1'b1;
			S_RAT:  cmd.ratio    = 1'b1;
			S_MUL:  cmd.mul      = 1'b1;
			S_TERM: cmd.term     = 1'b1;
			S_OUT:  cmd.out_load = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

FILE: hw/rtl/plto_dp.sv
// Datapath: pass-point tables, breakpoint search, divider, multiplier and output register.
module plto_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  plto_pkg::cmd_t                   cmd,
	output plto_pkg::stat_t                  stat,
	input  logic [plto_pkg::PT_W-1:0]        point_index,
	input  logic [plto_pkg::JNT_W-1:0]       joint_index,
	input  logic [plto_pkg::DATA_W-1:0]      time_value,
	input  logic [plto_pkg::DATA_W-1:0]      data_value,
	input  logic                             cfg_we,
	input  logic [plto_pkg::CFG_W-1:0]       cfg_wdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [plto_pkg::DATA_W-1:0]      joint_result,
	output logic [plto_pkg::STAT_W-1:0]      status
);
	import plto_pkg::*;

	logic [CFG_W-1:0]          points_q;
	logic [TIME_AW-1:0]        last_pt;

	logic [TIME_AW-1:0]        time_raddr;
	logic [DATA_W-1:0]         time_rdata;
	logic [VAL_AW-1:0]         val_raddr;
	logic [DATA_W-1:0]         val_rdata;

	logic signed [DATA_W-1:0]  t_q;
	logic signed [DATA_W-1:0]  base_q;
	logic [JNT_W-1:0]          joint_q;
	logic [TIME_AW-1:0]        idx_q;
	logic signed [DATA_W-1:0]  prev_q;
	logic signed [DATA_W-1:0]  cur_q;
	logic                      clamped_q;
	logic                      hit;
	logic                      first;
	logic                      last;

	logic signed [DATA_W:0]    dt_q;
	logic signed [DATA_W:0]    dx_q;
	logic [DATA_W:0]           dtm;
	logic [DATA_W:0]           dxm;
	logic [DATA_W:0]           dxm_q;
	logic [DATA_W:0]           rem_q;
	logic [DATA_W-1:0]         numlo_q;
	logic [DATA_W-1:0]         quo_q;
	logic [DATA_W+1:0]         shifted;
	logic                      ge;
	logic                      neg_q;
	logic                      zero_q;
	logic                      big_q;
	logic [CNT_W-1:0]          cnt_q;

	logic signed [DATA_W-1:0]  y0_q;
	logic signed [DATA_W-1:0]  y1_q;
	logic signed [DATA_W:0]    dy;
	logic signed [DATA_W-1:0]  ratio_q;
	logic                      sat_q;
	logic signed [2*DATA_W:0]  prod_q;
	logic signed [2*DATA_W:0]  prod_rnd;
	logic signed [2*DATA_W-16:0] term_q;
	logic signed [DATA_W+18:0] sum_w;
	logic signed [DATA_W-1:0]  res;
	logic                      res_sat;
	status_t                   res_status;

	logic                      m_tvalid_q;
	logic [DATA_W-1:0]         m_data_q;
	logic [STAT_W-1:0]         m_stat_q;

	// config register and effective last point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= POINTS_RST;
		end else if (cfg_we) begin
			points_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (int'(points_q) < 2) begin
			last_pt = TIME_AW'(1);
		end else if (int'(points_q) > MAX_POINTS) begin
			last_pt = TIME_AW'(MAX_POINTS - 1);
		end else begin
			last_pt = TIME_AW'(points_q - CFG_W'(1));
		end
	end

	// tables
	assign time_raddr = cmd.srch_ahead ? idx_q + TIME_AW'(1) : idx_q;
	assign val_raddr  = val_addr(cmd.rd_y1 ? idx_q : idx_q - TIME_AW'(1), joint_q);

	plto_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_POINTS)
	) u_time_ram (
		.clk  (clk),
		.we   (cmd.wr_time && pt_ok(point_index)),
		.waddr(TIME_AW'(point_index)),
		.wdata(time_value),
		.raddr(time_raddr),
		.rdata(time_rdata)
	);

	plto_ram #(
		.WIDTH(DATA_W),
		.DEPTH(VAL_DEPTH)
	) u_val_ram (
		.clk  (clk),
		.we   (cmd.wr_val && pt_ok(point_index) && jnt_ok(joint_index)),
		.waddr(val_addr(TIME_AW'(point_index), joint_index)),
		.wdata(data_value),
		.raddr(val_raddr),
		.rdata(val_rdata)
	);

	// breakpoint search
	assign hit   = $signed(time_rdata) > t_q;
	assign first = (idx_q == '0);
	assign last  = (idx_q == last_pt);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q     <= $signed(time_value);
			base_q  <= $signed(data_value);
			joint_q <= joint_index;
			idx_q   <= '0;
		end else if (cmd.cmp) begin
			prev_q <= cur_q;
			cur_q  <= $signed(time_rdata);
			if (first && hit) begin
				t_q <= $signed(time_rdata);
			end
			if (!stat.stop) begin
				idx_q <= idx_q + TIME_AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamped_q <= 1'b0;
		end else if (cmd.load) begin
			clamped_q <= 1'b0;
		end else if (cmd.cmp && first && hit) begin
			clamped_q <= 1'b1;
		end
	end

	// operand set-up and divider
	assign dtm     = dt_q[DATA_W] ? (DATA_W+1)'(1) + ~dt_q : dt_q;
	assign dxm     = dx_q[DATA_W] ? (DATA_W+1)'(1) + ~dx_q : dx_q;
	assign shifted = {rem_q, numlo_q[DATA_W-1]};
	assign ge      = shifted >= {1'b0, dxm_q};

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			dt_q <= {t_q[DATA_W-1], t_q} - {prev_q[DATA_W-1], prev_q};
			dx_q <= {cur_q[DATA_W-1], cur_q} - {prev_q[DATA_W-1], prev_q};
		end
		if (cmd.lat_y0) begin
			y0_q <= jnt_ok(joint_q) ? $signed(val_rdata) : '0;
		end
		if (cmd.lat_y1) begin
			y1_q <= jnt_ok(joint_q) ? $signed(val_rdata) : '0;
		end
		if (cmd.div_prep) begin
			dxm_q   <= dxm;
			zero_q  <= (dx_q == '0);
			neg_q   <= dt_q[DATA_W] ^ dx_q[DATA_W];
			big_q   <= {16'b0, dtm[DATA_W:16]} >= dxm;
			rem_q   <= {16'b0, dtm[DATA_W:16]};
			numlo_q <= {dtm[15:0], 16'b0};
			quo_q   <= '0;
		end else if (cmd.div_step) begin
			rem_q   <= ge ? (DATA_W+1)'(shifted - {1'b0, dxm_q}) : shifted[DATA_W:0];
			quo_q   <= {quo_q[DATA_W-2:0], ge};
			numlo_q <= {numlo_q[DATA_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_prep) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// ratio, product and term
	assign dy       = {y1_q[DATA_W-1], y1_q} - {y0_q[DATA_W-1], y0_q};
	assign prod_rnd = prod_q + (prod_q[2*DATA_W] ? (2*DATA_W+1)'(65535) : '0);

	always_ff @(posedge clk) begin
		if (cmd.ratio) begin
			if (zero_q) begin
				ratio_q <= '0;
				sat_q   <= 1'b0;
			end else if (big_q) begin
				ratio_q <= neg_q ? Q_MIN : Q_MAX;
				sat_q   <= 1'b1;
			end else if (neg_q) begin
				if (quo_q > DATA_W'(32'h8000_0000)) begin
					ratio_q <= Q_MIN;
					sat_q   <= 1'b1;
				end else begin
					ratio_q <= $signed(DATA_W'(0) - quo_q);
					sat_q   <= 1'b0;
				end
			end else begin
				ratio_q <= quo_q[DATA_W-1] ? Q_MAX : $signed(quo_q);
				sat_q   <= quo_q[DATA_W-1];
			end
		end
		if (cmd.mul) begin
			prod_q <= (2*DATA_W+1)'(dy) * (2*DATA_W+1)'(ratio_q);
		end
		if (cmd.term) begin
			term_q <= prod_rnd[2*DATA_W:16];
		end
	end

	// final sum and saturation
	assign sum_w = (DATA_W+19)'(y0_q) + (DATA_W+19)'(term_q) + (DATA_W+19)'(base_q);

	always_comb begin
		res_sat = 1'b0;
		res     = sum_w[DATA_W-1:0];
		if (sum_w > (DATA_W+19)'(Q_MAX)) begin
			res_sat = 1'b1;
			res     = Q_MAX;
		end else if (sum_w < (DATA_W+19)'(Q_MIN)) begin
			res_sat = 1'b1;
			res     = Q_MIN;
		end
		if (sat_q || res_sat) begin
			res_status = ST_SAT;
		end else if (zero_q) begin
			res_status = ST_ZERO;
		end else if (clamped_q) begin
			res_status = ST_CLAMP;
		end else begin
			res_status = ST_OK;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_data_q <= res;
			m_stat_q <= res_status;
		end
	end

	assign m_tvalid     = m_tvalid_q;
	assign joint_result = m_data_q;
	assign status       = m_stat_q;

	assign stat.stop     = !first && (hit || last || clamped_q);
	assign stat.div_skip = zero_q || big_q;
	assign stat.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign stat.out_free = !m_tvalid_q || m_tready;

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over a beat not yet taken");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid_q)
		else $error("loaded result not presented");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < dxm_q))
		else $error("divider remainder not below divisor");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cmp |-> (idx_q <= last_pt))
		else $error("search ran past last point");

	a_zero_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> (!zero_q || ratio_q == '0))
		else $error("zero interval with non-zero ratio");
`endif

endmodule
